// ----- src/pal_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// pal_pkg
// Shared types and constants of the positional array list.
// ---------------------------------------------------------------------------
package pal_pkg;

  // Widths fixed by the request and result fields.
  localparam int KIND_W  = 2;
  localparam int POS_W   = 4;
  localparam int WORD_W  = 32;
  localparam int CNT_W   = 5;
  localparam int STAT_W  = 2;
  localparam int APB_W   = 32;
  localparam int ADDR_W  = 2;

  // Largest value the capacity register can hold.
  localparam int CAP_REG_MAX = 31;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_GET    = 2'd1,
    KIND_DELETE = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic [ADDR_W-1:0] {
    REG_CAPACITY = 2'd0
  } reg_addr_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_RESP = 1'b1
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic exec;  // perform the request on the input ports this cycle
  } cmd_t;

endpackage
`default_nettype wire

// ----- src/pal_ctrl.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// pal_ctrl
// Request controller: accepts a request, then presents its result for one
// cycle.
// ---------------------------------------------------------------------------
module pal_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output pal_pkg::cmd_t      cmd,
  output logic               busy,
  output logic               out_valid
);

  pal_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pal_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd.exec  = 1'b0;
    busy      = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      pal_pkg::S_IDLE: begin
        if (start) begin
          cmd.exec  = 1'b1;
          state_nxt = pal_pkg::S_RESP;
        end
      end
      pal_pkg::S_RESP: begin
        busy      = 1'b1;
        out_valid = 1'b1;
        state_nxt = pal_pkg::S_IDLE;
      end
      default: begin
        state_nxt = pal_pkg::S_IDLE;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  // A result strobe lasts exactly one cycle.
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  // Every request taken is answered by a strobe in the cycle after.
  a_strobe_follows_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> out_valid)
    else $error("accepted request produced no result");

  // No request is taken while a result is on the ports.
  a_no_exec_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !cmd.exec)
    else $error("request taken while busy");
`endif

endmodule
`default_nettype wire

// ----- src/pal_dpath.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// pal_dpath
// List storage and request datapath: a row of word cells that shifts up on
// insert and down on delete.
// ---------------------------------------------------------------------------
module pal_dpath #(
  parameter int DEPTH = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire pal_pkg::cmd_t                cmd,
  input  wire logic [pal_pkg::KIND_W-1:0]   kind,
  input  wire logic [pal_pkg::POS_W-1:0]    position,
  input  wire logic [pal_pkg::WORD_W-1:0]   entry_value,
  input  wire logic [pal_pkg::CNT_W-1:0]    cap_limit,
  output logic      [pal_pkg::STAT_W-1:0]   status,
  output logic      [pal_pkg::WORD_W-1:0]   read_value,
  output logic      [pal_pkg::CNT_W-1:0]    list_length
);

  // The capacity register cannot exceed its own range, so cells beyond it
  // would never be used.
  localparam int NCELL = (DEPTH < pal_pkg::CAP_REG_MAX) ? DEPTH : pal_pkg::CAP_REG_MAX;
  localparam logic [pal_pkg::CNT_W-1:0] CAP_MAX = NCELL[pal_pkg::CNT_W-1:0];

  logic [pal_pkg::WORD_W-1:0] cells_r   [NCELL];
  logic [pal_pkg::WORD_W-1:0] cells_nxt [NCELL];
  logic [pal_pkg::CNT_W-1:0]  count_r, count_nxt;
  pal_pkg::status_t           status_r, status_nxt;
  logic [pal_pkg::WORD_W-1:0] rd_r, rd_nxt;

  pal_pkg::kind_t             kind_c;
  logic [pal_pkg::CNT_W-1:0]  pos_c;
  logic [pal_pkg::CNT_W-1:0]  cap_eff;
  logic [pal_pkg::CNT_W-1:0]  ins_pos;
  logic [pal_pkg::CNT_W-1:0]  del_pos;
  logic [pal_pkg::CNT_W-1:0]  sel_pos;
  logic [pal_pkg::WORD_W-1:0] sel_word;

  assign kind_c = pal_pkg::kind_t'(kind);
  assign pos_c  = {1'b0, position};

  always_comb begin
    if (cap_limit == '0) begin
      cap_eff = {{(pal_pkg::CNT_W-1){1'b0}}, 1'b1};
    end else if (cap_limit > CAP_MAX) begin
      cap_eff = CAP_MAX;
    end else begin
      cap_eff = cap_limit;
    end
  end

  // Insert past the end appends; delete past the end takes the last entry.
  assign ins_pos = (pos_c > count_r) ? count_r : pos_c;
  assign del_pos = (pos_c >= count_r) ? count_r - 1'b1 : pos_c;
  assign sel_pos = (kind_c == pal_pkg::KIND_GET) ? pos_c : del_pos;

  always_comb begin
    sel_word = '0;
    for (int i = 0; i < NCELL; i++) begin
      if (sel_pos == pal_pkg::CNT_W'(i)) begin
        sel_word = cells_r[i];
      end
    end
  end

  always_comb begin
    cells_nxt  = cells_r;
    count_nxt  = count_r;
    status_nxt = pal_pkg::ST_OK;
    rd_nxt     = '0;
    unique case (kind_c)
      pal_pkg::KIND_INSERT: begin
        if (count_r >= cap_eff) begin
          status_nxt = pal_pkg::ST_FULL;
        end else begin
          for (int i = 0; i < NCELL; i++) begin
            if (pal_pkg::CNT_W'(i) == ins_pos) begin
              cells_nxt[i] = entry_value;
            end else if (pal_pkg::CNT_W'(i) > ins_pos && pal_pkg::CNT_W'(i) <= count_r) begin
              cells_nxt[i] = cells_r[(i > 0) ? i - 1 : 0];
            end
          end
          count_nxt = count_r + 1'b1;
        end
      end
      pal_pkg::KIND_GET: begin
        if (pos_c >= count_r) begin
          status_nxt = pal_pkg::ST_RANGE;
        end else begin
          rd_nxt = sel_word;
        end
      end
      pal_pkg::KIND_DELETE: begin
        if (count_r == '0) begin
          status_nxt = pal_pkg::ST_EMPTY;
        end else begin
          rd_nxt = sel_word;
          for (int i = 0; i < NCELL - 1; i++) begin
            if (pal_pkg::CNT_W'(i) >= del_pos && pal_pkg::CNT_W'(i + 1) < count_r) begin
              cells_nxt[i] = cells_r[i + 1];
            end
          end
          count_nxt = count_r - 1'b1;
        end
      end
      pal_pkg::KIND_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.exec) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      cells_r  <= cells_nxt;
      status_r <= status_nxt;
      rd_r     <= rd_nxt;
    end
  end

  assign status      = status_r;
  assign read_value  = rd_r;
  assign list_length = count_r;

`ifndef NO_ASSERTIONS
  // The count never passes the number of cells.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_MAX)
    else $error("entry count beyond cell row");

  // A clear empties the list.
  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && kind_c == pal_pkg::KIND_CLEAR) |=> count_r == '0)
    else $error("clear left entries behind");

  // Get never changes the length.
  a_get_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && kind_c == pal_pkg::KIND_GET) |=> $stable(count_r))
    else $error("get changed the list length");
`endif

endmodule
`default_nettype wire

// ----- src/positional_array_list.sv -----
`default_nettype none
// A result appears on the out_ ports in the cycle after start is taken.
// No new request is taken while busy; busy is high during the result
// cycle, set by the two-state request controller.
// Insert and delete shift the cells from the position to the end of the list in the cycle the request is taken.
// Reset (rst_n low, synchronous) empties the list and sets capacity to 16.
// ---------------------------------------------------------------------------
// positional_array_list
// Bounded ordered list of 32-bit words with insert, get, delete and clear
// at a position, and an APB-style register for the capacity limit.
// ---------------------------------------------------------------------------
module positional_array_list #(
  parameter int DEPTH = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [pal_pkg::KIND_W-1:0]    in_kind,
  input  wire logic [pal_pkg::POS_W-1:0]     in_position,
  input  wire logic [pal_pkg::WORD_W-1:0]    in_entry_value,
  output logic                               out_valid,
  output logic      [pal_pkg::STAT_W-1:0]    out_status,
  output logic      [pal_pkg::WORD_W-1:0]    out_read_value,
  output logic      [pal_pkg::CNT_W-1:0]     out_list_length,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [pal_pkg::ADDR_W-1:0]    paddr,
  input  wire logic [pal_pkg::APB_W-1:0]     pwdata,
  output logic      [pal_pkg::APB_W-1:0]     prdata,
  output logic                               pready
);

  pal_pkg::cmd_t             cmd;
  logic [pal_pkg::CNT_W-1:0] cap_r;
  logic                      cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready
                  && (paddr == pal_pkg::REG_CAPACITY);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= pal_pkg::CNT_W'(16);
    end else if (cfg_wr) begin
      cap_r <= pwdata[pal_pkg::CNT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == pal_pkg::REG_CAPACITY) begin
      prdata = {{(pal_pkg::APB_W-pal_pkg::CNT_W){1'b0}}, cap_r};
    end
  end

  pal_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  pal_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .kind        (in_kind),
    .position    (in_position),
    .entry_value (in_entry_value),
    .cap_limit   (cap_r),
    .status      (out_status),
    .read_value  (out_read_value),
    .list_length (out_list_length)
  );

`ifndef NO_ASSERTIONS
  // Each result answers a transfer taken in the previous cycle.
  a_result_has_request: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy))
    else $error("result without a request");

  // The capacity register only changes on a completed write.
  a_cap_write_only: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(cfg_wr) |-> $stable(cap_r))
    else $error("capacity changed without a write");

  // A full refusal leaves the length where it was.
  a_full_keeps_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == pal_pkg::ST_FULL) |-> $stable(out_list_length))
    else $error("refused insert changed the length");
`endif

endmodule
`default_nettype wire
